>>> rtl/core/swo_pkg.sv
// ----------------------------------------------------------------------------
// swo_pkg
// Shared types and constants for the sample offset walker.
// ----------------------------------------------------------------------------
package swo_pkg;

    // input field widths
    localparam int IDX_W    = 12;
    localparam int START_W  = 13;
    localparam int COUNT_W  = 16;
    localparam int OFFSET_W = 32;
    localparam int SIZE_W   = 32;

    // result field widths
    localparam int SNUM_W   = 32;
    localparam int CNUM_W   = 12;

    // configuration registers
    localparam int MAP_ENT_W = 9;
    localparam int CHK_CNT_W = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAP_ENTRIES = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_CHUNK_COUNT = 1'b1;

    // stream widths
    localparam int IN_TDATA_W  = 112;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_TUSER_W = 1;

    typedef enum logic [IN_TUSER_W-1:0] {
        REQ_LOAD_MAP    = 2'd0,
        REQ_LOAD_OFFSET = 2'd1,
        REQ_NEXT        = 2'd2,
        REQ_RESTART     = 2'd3
    } t_req;

    localparam logic [OUT_TUSER_W-1:0] STAT_OK   = 1'b0;
    localparam logic [OUT_TUSER_W-1:0] STAT_DONE = 1'b1;

    // store write port
    typedef struct packed {
        logic                map_we;
        logic                chunk_we;
        logic [IDX_W-1:0]    idx;
        logic [START_W-1:0]  start;
        logic [COUNT_W-1:0]  count;
        logic [OFFSET_W-1:0] offset;
    } t_store_wr;

endpackage

>>> rtl/core/swo_stores.sv
// ----------------------------------------------------------------------------
// swo_stores
// Chunk-map and chunk-offset memories, one write port, registered reads.
// ----------------------------------------------------------------------------
module swo_stores #(
    parameter int MAP_DEPTH   = 256,
    parameter int CHUNK_DEPTH = 4096,
    localparam int MAP_AW     = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1,
    localparam int CHUNK_AW   = (CHUNK_DEPTH > 1) ? $clog2(CHUNK_DEPTH) : 1
) (
    input  logic                              i_clk,
    input  swo_pkg::t_store_wr                i_wr,
    input  logic [MAP_AW-1:0]                 i_start_addr,
    input  logic [MAP_AW-1:0]                 i_count_addr,
    input  logic [CHUNK_AW-1:0]               i_base_addr,
    output logic [swo_pkg::START_W-1:0]       o_start_q,
    output logic [swo_pkg::COUNT_W-1:0]       o_count_q,
    output logic [swo_pkg::OFFSET_W-1:0]      o_base_q
);
    import swo_pkg::*;

    logic [START_W-1:0]  r_map_start [MAP_DEPTH];
    logic [COUNT_W-1:0]  r_map_count [MAP_DEPTH];
    logic [OFFSET_W-1:0] r_chunk_base [CHUNK_DEPTH];

    logic [31:0] idx_ext;
    logic        map_hit;
    logic        chunk_hit;

    assign idx_ext   = {{(32-IDX_W){1'b0}}, i_wr.idx};
    assign map_hit   = idx_ext < 32'(MAP_DEPTH);
    assign chunk_hit = idx_ext < 32'(CHUNK_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_wr.map_we && map_hit) begin
            r_map_start[idx_ext[MAP_AW-1:0]] <= i_wr.start;
            r_map_count[idx_ext[MAP_AW-1:0]] <= i_wr.count;
        end
        if (i_wr.chunk_we && chunk_hit) begin
            r_chunk_base[idx_ext[CHUNK_AW-1:0]] <= i_wr.offset;
        end
        o_start_q <= r_map_start[i_start_addr];
        o_count_q <= r_map_count[i_count_addr];
        o_base_q  <= r_chunk_base[i_base_addr];
    end

endmodule

>>> rtl/core/sample_offset_walker.sv
// ----------------------------------------------------------------------------
// sample_offset_walker
// Expands a chunk map and chunk offsets into per-sample file offsets.
// ----------------------------------------------------------------------------
// Load transactions (map entry, chunk offset) and restart are completed in
// S_IDLE when accepted. A next-sample transaction runs through a small
// sequencer around synchronous stores and one shared 32-bit adder: with the
// current chunk already entered, its steps are accept, store read, offset add
// and running-sum add. Entering a chunk adds S_ENTER and another store read;
// leaving one adds S_EMIT and S_CHECK. A done result is loaded from S_CHECK
// once the walk is past the last chunk. The registered store reads and the
// single adder set this order. The input is not ready while a next-sample
// transaction is in flight; a finished result sits in an output register and
// does not block the input. Configuration writes are meant for idle periods.
// ----------------------------------------------------------------------------
module sample_offset_walker #(
    parameter int MAP_DEPTH   = 256,
    parameter int CHUNK_DEPTH = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [swo_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [swo_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    // request stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // entry_index, first_chunk, samples_per_chunk, chunk_offset, sample_size
    input  logic [swo_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // req_type
    input  logic [swo_pkg::IN_TUSER_W-1:0]      i_s_axis_tuser,
    // result stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // sample_offset, sample_number, chunk_number
    output logic [swo_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // status
    output logic [swo_pkg::OUT_TUSER_W-1:0]     o_m_axis_tuser
);
    import swo_pkg::*;

    localparam int MAP_AW   = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int CHUNK_AW = (CHUNK_DEPTH > 1) ? $clog2(CHUNK_DEPTH) : 1;
    localparam int ENT_W    = MAP_AW + 1;    // holds MAP_DEPTH itself
    localparam int CP_W     = CHUNK_AW + 1;  // holds CHUNK_DEPTH itself

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,   // store reads in flight, end-of-track test
        S_ENTER,   // chunk entry: maybe step the map
        S_EMIT,    // emit sample or leave the chunk
        S_ACC      // running offset += sample size
    } t_state;

    // request fields
    logic [IDX_W-1:0]    f_idx;
    logic [START_W-1:0]  f_start;
    logic [COUNT_W-1:0]  f_count;
    logic [OFFSET_W-1:0] f_offset;
    logic [SIZE_W-1:0]   f_size;
    t_req                f_req;

    assign f_idx    = i_s_axis_tdata[11:0];
    assign f_start  = i_s_axis_tdata[24:12];
    assign f_count  = i_s_axis_tdata[40:25];
    assign f_offset = i_s_axis_tdata[72:41];
    assign f_size   = i_s_axis_tdata[104:73];
    assign f_req    = t_req'(i_s_axis_tuser);

    // config registers
    logic [MAP_ENT_W-1:0] r_map_entries;
    logic [CHK_CNT_W-1:0] r_chunk_count;

    // walk state
    t_state              r_state;
    logic [CP_W-1:0]     r_chunk_pos;
    logic [MAP_AW-1:0]   r_map_pos;
    logic [COUNT_W-1:0]  r_in_chunk;
    logic [OFFSET_W-1:0] r_run_off;
    logic [SNUM_W-1:0]   r_sample_cnt;
    logic                r_entered;
    logic [SIZE_W-1:0]   r_size;

    // result register
    logic                r_out_valid;
    logic                r_out_status;
    logic [OFFSET_W-1:0] r_out_offset;
    logic [SNUM_W-1:0]   r_out_number;
    logic [CNUM_W-1:0]   r_out_chunk;

    logic                in_acc;
    logic                out_free;
    logic                out_load;
    logic [ENT_W-1:0]    live_ent;
    logic [CP_W-1:0]     live_chk;
    logic [ENT_W-1:0]    map_nx;
    logic                map_step;
    logic [31:0]         map_ent_ext;
    logic [31:0]         chk_cnt_ext;
    logic [31:0]         chunk_pos_ext;

    t_store_wr           st_wr;
    logic [START_W-1:0]  start_q;
    logic [COUNT_W-1:0]  count_q;
    logic [OFFSET_W-1:0] base_q;

    // shared adder
    logic [OFFSET_W-1:0] add_a;
    logic [OFFSET_W-1:0] add_b;
    logic [OFFSET_W-1:0] add_sum;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    // live entry count: zero acts as one, clamp to depth
    assign map_ent_ext = {{(32-MAP_ENT_W){1'b0}}, r_map_entries};
    assign chk_cnt_ext = {{(32-CHK_CNT_W){1'b0}}, r_chunk_count};

    always_comb begin
        if (map_ent_ext == 32'd0) begin
            live_ent = ENT_W'(1);
        end else if (map_ent_ext > 32'(MAP_DEPTH)) begin
            live_ent = ENT_W'(MAP_DEPTH);
        end else begin
            live_ent = map_ent_ext[ENT_W-1:0];
        end
        if (chk_cnt_ext > 32'(CHUNK_DEPTH)) begin
            live_chk = CP_W'(CHUNK_DEPTH);
        end else begin
            live_chk = chk_cnt_ext[CP_W-1:0];
        end
    end

    assign chunk_pos_ext = {{(32-CP_W){1'b0}}, r_chunk_pos};
    assign map_nx        = {1'b0, r_map_pos} + ENT_W'(1);
    // next map entry starts at this (1-based) chunk
    assign map_step      = (map_nx < live_ent) &&
                           ({{(32-START_W){1'b0}}, start_q} == chunk_pos_ext + 32'd1);

    // result register loads this cycle (done or sample)
    assign out_load = out_free &&
                      (((r_state == S_CHECK) && (r_chunk_pos >= live_chk)) ||
                       ((r_state == S_EMIT) && (r_in_chunk < count_q)));

    assign add_a   = (r_state == S_ACC) ? r_run_off : base_q;
    assign add_b   = (r_state == S_ACC) ? r_size    : r_run_off;
    assign add_sum = add_a + add_b;

    // store writes come straight from accepted load transactions
    always_comb begin
        st_wr.map_we   = in_acc && (f_req == REQ_LOAD_MAP);
        st_wr.chunk_we = in_acc && (f_req == REQ_LOAD_OFFSET);
        st_wr.idx      = f_idx;
        st_wr.start    = f_start;
        st_wr.count    = f_count;
        st_wr.offset   = f_offset;
    end

    swo_stores #(
        .MAP_DEPTH   (MAP_DEPTH),
        .CHUNK_DEPTH (CHUNK_DEPTH)
    ) u_stores (
        .i_clk        (i_clk),
        .i_wr         (st_wr),
        .i_start_addr (map_nx[MAP_AW-1:0]),
        .i_count_addr (r_map_pos),
        .i_base_addr  (r_chunk_pos[CHUNK_AW-1:0]),
        .o_start_q    (start_q),
        .o_count_q    (count_q),
        .o_base_q     (base_q)
    );

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_entries <= MAP_ENT_W'(1);
            r_chunk_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_MAP_ENTRIES: r_map_entries <= i_cfg_wdata[MAP_ENT_W-1:0];
                REG_CHUNK_COUNT: r_chunk_count <= i_cfg_wdata[CHK_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_chunk_pos  <= '0;
            r_map_pos    <= '0;
            r_in_chunk   <= '0;
            r_run_off    <= '0;
            r_sample_cnt <= '0;
            r_entered    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (f_req)
                            REQ_NEXT: begin
                                r_size <= f_size;
                                // map may have shrunk since the last step
                                if ({1'b0, r_map_pos} >= live_ent) begin
                                    r_map_pos <= MAP_AW'(live_ent - ENT_W'(1));
                                end
                                r_state <= S_CHECK;
                            end
                            REQ_RESTART: begin
                                r_chunk_pos  <= '0;
                                r_map_pos    <= '0;
                                r_in_chunk   <= '0;
                                r_run_off    <= '0;
                                r_sample_cnt <= '0;
                                r_entered    <= 1'b0;
                            end
                            REQ_LOAD_MAP, REQ_LOAD_OFFSET: ;
                        endcase
                    end
                end
                S_CHECK: begin
                    if (r_chunk_pos >= live_chk) begin
                        if (out_free) begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= STAT_DONE;
                            r_out_offset <= '0;
                            r_out_number <= '0;
                            r_out_chunk  <= '0;
                            r_state      <= S_IDLE;
                        end
                    end else if (!r_entered) begin
                        r_state <= S_ENTER;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_ENTER: begin
                    if (map_step) begin
                        r_map_pos <= map_nx[MAP_AW-1:0];
                    end
                    r_entered  <= 1'b1;
                    r_in_chunk <= '0;
                    r_run_off  <= '0;
                    r_state    <= S_CHECK;   // re-read count for new map entry
                end
                S_EMIT: begin
                    if (r_in_chunk < count_q) begin
                        if (out_free) begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= STAT_OK;
                            r_out_offset <= add_sum;
                            r_out_number <= r_sample_cnt;
                            r_out_chunk  <= chunk_pos_ext[CNUM_W-1:0];
                            r_in_chunk   <= r_in_chunk + COUNT_W'(1);
                            r_sample_cnt <= r_sample_cnt + SNUM_W'(1);
                            r_state      <= S_ACC;
                        end
                    end else begin
                        // chunk exhausted or empty
                        r_chunk_pos <= r_chunk_pos + CP_W'(1);
                        r_entered   <= 1'b0;
                        r_state     <= S_CHECK;
                    end
                end
                S_ACC: begin
                    r_run_off <= add_sum;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {
        {(OUT_TDATA_W - OFFSET_W - SNUM_W - CNUM_W){1'b0}},
        r_out_chunk, r_out_number, r_out_offset
    };

endmodule

>>> rtl/core/swo_checker.sv
// ----------------------------------------------------------------------------
// swo_checker
// Port-level checks for the sample offset walker, bound to the top level.
// ----------------------------------------------------------------------------
module swo_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_axis_tvalid,
    input logic                                o_s_axis_tready,
    input logic [swo_pkg::IN_TUSER_W-1:0]      i_s_axis_tuser,
    input logic                                o_m_axis_tvalid,
    input logic                                i_m_axis_tready,
    input logic [swo_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    input logic [swo_pkg::OUT_TUSER_W-1:0]     o_m_axis_tuser
);
    import swo_pkg::*;

    logic in_xact;
    assign in_xact = i_s_axis_tvalid && o_s_axis_tready;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // done result carries all-zero fields
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == STAT_DONE |-> o_m_axis_tdata == '0)
        else $error("done result with nonzero fields");

    // next-sample transaction occupies the sequencer
    a_next_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xact && i_s_axis_tuser == REQ_NEXT |=> !o_s_axis_tready)
        else $error("ready right after next-sample transaction");

    // loads and restart produce no result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xact && i_s_axis_tuser != REQ_NEXT && !o_m_axis_tvalid |=> !o_m_axis_tvalid)
        else $error("result from a load or restart");

    // reset leaves an idle, empty block
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("not idle after reset");

endmodule

bind sample_offset_walker swo_checker u_swo_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sample offset walker.
// ----------------------------------------------------------------------------
// Sends map loads, chunk offset loads, restarts and next-sample transactions
// on the request stream. A tracker keeps its own copy of the stores and of
// the walk. For every accepted next-sample transaction it predicts the result.
// Each accepted result is compared field by field with the oldest prediction.
// A short directed run covers these cases: the done status on an empty track,
// offset wrap, zero-sample chunks, the end of the track, restart, and a load
// during a walk. Random phases then sweep the register extremes under three
// back-pressure mixes. Store entries are loaded on demand, so the walk never
// reads an entry that was never written.
// ----------------------------------------------------------------------------
module testbench;
    import swo_pkg::*;

    localparam int MAP_DEPTH     = 256;
    localparam int CHUNK_DEPTH   = 4096;
    localparam int PHASE_ITEMS   = 180;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS   = 10;
    localparam int CYCLE_LIMIT   = 2_000_000;

    typedef struct {
        t_req                kind;
        logic [IDX_W-1:0]    idx;
        logic [START_W-1:0]  first_chunk;
        logic [COUNT_W-1:0]  spc;
        logic [OFFSET_W-1:0] base;
        logic [SIZE_W-1:0]   sample_size;
    } walk_request;

    typedef struct packed {
        logic [OUT_TUSER_W-1:0] status;
        logic [OFFSET_W-1:0]    offset;
        logic [SNUM_W-1:0]      number;
        logic [CNUM_W-1:0]      chunk;
    } sample_entry;

    // ------------------------------------------------------------------------
    // Tracker: stores, walk state and the predicted results still to come
    // ------------------------------------------------------------------------
    class sample_offset_tracker;
        logic [MAP_ENT_W-1:0] map_entries;
        logic [CHK_CNT_W-1:0] chunk_count;
        logic [START_W-1:0]   start_mem [MAP_DEPTH];
        logic [COUNT_W-1:0]   count_mem [MAP_DEPTH];
        bit                   map_loaded [MAP_DEPTH];
        logic [OFFSET_W-1:0]  base_mem [CHUNK_DEPTH];
        bit                   base_loaded [CHUNK_DEPTH];
        int unsigned          chunk_pos;
        int unsigned          map_pos;
        int unsigned          in_chunk_cnt;
        logic [OFFSET_W-1:0]  run_offset;
        logic [SNUM_W-1:0]    sample_cnt;
        bit                   chunk_open;
        sample_entry          expected_samples [$];
        int unsigned          results_seen;
        int unsigned          fail_count;

        function new();
            map_entries  = 1;
            chunk_count  = 0;
            results_seen = 0;
            fail_count   = 0;
            clear_walk();
        endfunction

        function void clear_walk();
            chunk_pos    = 0;
            map_pos      = 0;
            in_chunk_cnt = 0;
            run_offset   = '0;
            sample_cnt   = '0;
            chunk_open   = 1'b0;
        endfunction

        // zero acts as one entry; both registers clamp to the store depth
        function int unsigned live_entries();
            int unsigned n;
            n = map_entries;
            if (n == 0) n = 1;
            if (n > MAP_DEPTH) n = MAP_DEPTH;
            return n;
        endfunction

        function int unsigned live_chunks();
            return (chunk_count > CHUNK_DEPTH) ? CHUNK_DEPTH : chunk_count;
        endfunction

        function void set_registers(input int unsigned ent, input int unsigned chk);
            map_entries = MAP_ENT_W'(ent);
            chunk_count = CHK_CNT_W'(chk);
        endfunction

        // Walks to the next sample on local copies of the state. It returns 0
        // and names the missing entry when the walk would read an unloaded
        // one. The state is updated only when commit is set.
        function bit advance(input bit commit, input logic [SIZE_W-1:0] sample_size,
                             output sample_entry res, output bit miss_map,
                             output int unsigned miss_idx, output int unsigned miss_chunk);
            int unsigned ents, chks, cpos, mpos, icnt, nx;
            logic [OFFSET_W-1:0] roff;
            bit opened;
            ents = live_entries();
            chks = live_chunks();
            cpos = chunk_pos;
            mpos = map_pos;
            icnt = in_chunk_cnt;
            roff = run_offset;
            opened = chunk_open;
            res = '0;
            res.status = STAT_DONE;
            miss_map = 1'b0;
            miss_idx = 0;
            miss_chunk = 0;
            if (mpos >= ents) mpos = ents - 1;
            while (cpos < chks) begin
                if (!opened) begin
                    nx = mpos + 1;
                    if (nx < ents) begin
                        if (!map_loaded[nx]) begin
                            miss_map = 1'b1;
                            miss_idx = nx;
                            miss_chunk = cpos;
                            return 1'b0;
                        end
                        if (start_mem[nx] == cpos + 1) mpos = nx;
                    end
                    opened = 1'b1;
                    icnt = 0;
                    roff = '0;
                end
                if (!map_loaded[mpos]) begin
                    miss_map = 1'b1;
                    miss_idx = mpos;
                    miss_chunk = cpos;
                    return 1'b0;
                end
                if (icnt < count_mem[mpos]) begin
                    if (!base_loaded[cpos]) begin
                        miss_idx = cpos;
                        miss_chunk = cpos;
                        return 1'b0;
                    end
                    res.status = STAT_OK;
                    res.offset = base_mem[cpos] + roff;
                    res.number = sample_cnt;
                    res.chunk  = CNUM_W'(cpos);
                    roff = roff + sample_size;
                    icnt++;
                    break;
                end
                cpos++;
                opened = 1'b0;
            end
            if (commit) begin
                chunk_pos    = cpos;
                map_pos      = mpos;
                in_chunk_cnt = icnt;
                run_offset   = roff;
                chunk_open   = opened;
                if (res.status == STAT_OK) sample_cnt = sample_cnt + 1'b1;
            end
            return 1'b1;
        endfunction

        // called at the edge where a request transaction is accepted
        function void note_request(input walk_request r);
            sample_entry res;
            bit miss_map;
            int unsigned miss_idx, miss_chunk;
            case (r.kind)
                REQ_LOAD_MAP: begin
                    if (r.idx < MAP_DEPTH) begin
                        start_mem[r.idx]  = r.first_chunk;
                        count_mem[r.idx]  = r.spc;
                        map_loaded[r.idx] = 1'b1;
                    end
                end
                REQ_LOAD_OFFSET: begin
                    if (r.idx < CHUNK_DEPTH) begin
                        base_mem[r.idx]    = r.base;
                        base_loaded[r.idx] = 1'b1;
                    end
                end
                REQ_RESTART: clear_walk();
                REQ_NEXT: begin
                    if (advance(1'b1, r.sample_size, res, miss_map, miss_idx, miss_chunk))
                        expected_samples.push_back(res);
                    else
                        fail_count++;
                end
            endcase
        endfunction

        // called at the edge where a result transaction is accepted
        function void check_result(input logic [OUT_TUSER_W-1:0] status,
                                   input logic [OUT_TDATA_W-1:0] data);
            sample_entry want, got;
            logic [OUT_TDATA_W-OFFSET_W-SNUM_W-CNUM_W-1:0] pad;
            got.status = status;
            got.offset = data[OFFSET_W-1:0];
            got.number = data[OFFSET_W+SNUM_W-1:OFFSET_W];
            got.chunk  = data[OFFSET_W+SNUM_W+CNUM_W-1:OFFSET_W+SNUM_W];
            pad = data[OUT_TDATA_W-1:OFFSET_W+SNUM_W+CNUM_W];
            results_seen++;
            if (expected_samples.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("result %0d: none pending, got status %0d offset %h number %0d",
                             results_seen, got.status, got.offset, got.number);
                return;
            end
            want = expected_samples.pop_front();
            if (got.status !== want.status || got.offset !== want.offset ||
                got.number !== want.number || got.chunk !== want.chunk || pad !== '0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $write("result %0d: expected status %0d offset %h number %0d chunk %0d,",
                           results_seen, want.status, want.offset, want.number, want.chunk);
                    $display(" got status %0d offset %h number %0d chunk %0d pad %h",
                             got.status, got.offset, got.number, got.chunk, pad);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and its inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // entry_index, first_chunk, samples_per_chunk, chunk_offset, sample_size
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    // req_type
    logic [IN_TUSER_W-1:0]  i_s_axis_tuser = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // sample_offset, sample_number, chunk_number
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    // status
    logic [OUT_TUSER_W-1:0] o_m_axis_tuser;

    sample_offset_tracker tracker;
    int unsigned send_idle_pct = 30;
    int unsigned recv_idle_pct = 73;
    int unsigned cycle_cnt = 0;

    sample_offset_walker #(
        .MAP_DEPTH   (MAP_DEPTH),
        .CHUNK_DEPTH (CHUNK_DEPTH)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Result side: check at the edge where the transaction is accepted, then
    // draw tready for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready)
            tracker.check_result(o_m_axis_tuser, o_m_axis_tdata);
        i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // hang guard
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("sample_offset_walker: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Request builders: fields a transaction does not use carry random bits
    // ------------------------------------------------------------------------
    function automatic walk_request make_request(input t_req kind);
        walk_request r;
        r.kind        = kind;
        r.idx         = IDX_W'($urandom_range(4095));
        r.first_chunk = START_W'($urandom_range(8191));
        r.spc         = COUNT_W'($urandom_range(65535));
        r.base        = $urandom();
        r.sample_size = $urandom();
        return r;
    endfunction

    function automatic walk_request map_request(input int unsigned idx,
                                                input int unsigned first_chunk,
                                                input int unsigned spc);
        walk_request r;
        r = make_request(REQ_LOAD_MAP);
        r.idx         = IDX_W'(idx);
        r.first_chunk = START_W'(first_chunk);
        r.spc         = COUNT_W'(spc);
        return r;
    endfunction

    function automatic walk_request offset_request(input int unsigned idx,
                                                   input logic [OFFSET_W-1:0] base);
        walk_request r;
        r = make_request(REQ_LOAD_OFFSET);
        r.idx  = IDX_W'(idx);
        r.base = base;
        return r;
    endfunction

    // Start chunk near a target, so the walk really moves on to later entries.
    // Now and then it is anything the field allows.
    function automatic int unsigned random_start(input int unsigned near);
        return ($urandom_range(3) == 0) ? $urandom_range(8191) : near + $urandom_range(2);
    endfunction

    // mostly short chunks, zero included; rarely anything up to the field max
    function automatic int unsigned random_count();
        return ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(4);
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // One request transaction. tvalid stays high into the next call unless a
    // gap is drawn, so back-to-back transactions see no bubble.
    task automatic send_item(input walk_request r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= r.kind;
        i_s_axis_tdata  <= {{(IN_TDATA_W-IDX_W-START_W-COUNT_W-OFFSET_W-SIZE_W){1'b0}},
                            r.sample_size, r.base, r.spc, r.first_chunk, r.idx};
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        tracker.note_request(r);
    endtask

    // Next-sample transaction. First, any entry that the step would read
    // unloaded gets loaded with random content.
    task automatic issue_next(input logic [SIZE_W-1:0] sample_size);
        walk_request r;
        sample_entry res;
        bit miss_map;
        int unsigned miss_idx, miss_chunk;
        r = make_request(REQ_NEXT);
        r.sample_size = sample_size;
        while (!tracker.advance(1'b0, sample_size, res, miss_map, miss_idx, miss_chunk)) begin
            if (miss_map)
                send_item(map_request(miss_idx, random_start(miss_chunk + 1), random_count()));
            else
                send_item(offset_request(miss_idx, $urandom()));
        end
        send_item(r);
    endtask

    // hold the request side until every predicted result has come back
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.expected_samples.size() != 0);
    endtask

    // Idle-only register update: drain, let the pipe settle, write both.
    task automatic configure(input int unsigned ent, input int unsigned chk);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_MAP_ENTRIES;
        i_cfg_wdata <= CFG_DATA_W'(ent);
        @(posedge i_clk);
        i_cfg_addr  <= REG_CHUNK_COUNT;
        i_cfg_wdata <= CFG_DATA_W'(chk);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.set_registers(ent, chk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int unsigned n, pick, idx, ent, chk;
        tracker = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: track empty after reset -> done
        issue_next(32'h0);
        // entry 0 covers chunks 1-2, entry 1 (chunk 3) is empty, entry 2 from 4
        send_item(map_request(0, 1, 2));
        send_item(map_request(1, 3, 0));
        send_item(map_request(2, 4, 1));
        send_item(map_request(255, 8191, 65535));
        send_item(map_request(4095, 0, 0));           // out of range, dropped
        send_item(offset_request(0, 32'hFFFF_FFFE));
        send_item(offset_request(1, 32'h0000_0010));
        send_item(offset_request(2, 32'h1234_5678));
        send_item(offset_request(3, 32'h8000_0000));
        send_item(offset_request(4095, 32'hFFFF_FFFF));
        configure(3, 4);
        issue_next(32'hFFFF_FFFF);                   // offset sum wraps
        issue_next(32'd5);
        issue_next(32'd0);                           // chunk 1
        issue_next(32'd7);
        issue_next(32'd9);                           // skips empty chunk 2
        issue_next(32'd1);                           // past last chunk
        issue_next(32'hFFFF_FFFF);                   // still done
        send_item(make_request(REQ_RESTART));
        issue_next(32'd3);
        send_item(offset_request(0, 32'h0));         // rewrite during the walk
        issue_next(32'd4);
        send_item(make_request(REQ_RESTART));

        // random phases: register extremes, three idle mixes
        for (int ph = 0; ph < 9; ph++) begin
            send_idle_pct = (ph < 3) ? 30 : (ph < 6) ? 73 : 0;
            recv_idle_pct = (ph < 3) ? 73 : (ph < 6) ? 30 : 0;
            case (ph)
                0: begin ent = 3;   chk = 6;    end
                1: begin ent = 0;   chk = 9;    end
                2: begin ent = 256; chk = 4096; end
                3: begin ent = 1;   chk = 1;    end
                4: begin ent = 511; chk = 8191; end
                5: begin ent = 8;   chk = 0;    end
                6: begin ent = 17;  chk = 40;   end
                7: begin ent = 256; chk = 300;  end
                default: begin ent = 5; chk = 20; end
            endcase
            configure(ent, chk);
            n = 0;
            while (n < PHASE_ITEMS) begin
                if ($urandom_range(79) == 0) drain();
                pick = $urandom_range(99);
                if (pick < 62) begin
                    issue_next($urandom());
                    n++;
                end else if (pick < 65) begin
                    send_item(make_request(REQ_RESTART));
                    n++;
                end else if (pick < 81) begin
                    idx = ($urandom_range(3) == 0) ? $urandom_range(4095)
                                                   : $urandom_range(tracker.live_entries() - 1);
                    send_item(map_request(idx, random_start($urandom_range(1,
                                          tracker.live_chunks() + 1)), random_count()));
                    if (idx < MAP_DEPTH) n++;
                end else begin
                    idx = ($urandom_range(3) == 0 || tracker.live_chunks() == 0)
                          ? $urandom_range(4095) : $urandom_range(tracker.live_chunks() - 1);
                    send_item(offset_request(idx, $urandom()));
                    n++;
                end
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.fail_count == 0 && tracker.expected_samples.size() == 0)
            $display("sample_offset_walker: match");
        else
            $display("sample_offset_walker: mismatch");
        $finish;
    end

endmodule
